// File: hdl/oscillator_discipline_loop_macros.svh
// Assertion macros shared by the oscillator discipline loop RTL.
// Each macro expects signals named clock and reset in the scope that uses it.
`ifndef OSCILLATOR_DISCIPLINE_LOOP_MACROS_SVH
`define OSCILLATOR_DISCIPLINE_LOOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ODL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ODL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/odl_pkg.sv
// Shared types, constants and the control store of the oscillator discipline loop.
// No dependencies; used by odl_seq, odl_dp and oscillator_discipline_loop.
package odl_pkg;

   localparam int TGT_W     = 32;
   localparam int TOL_W     = 16;
   localparam int DAC_W     = 12;
   localparam int ADJ_W     = 2;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int MUL_BITS  = 7;
   localparam int CNT_W     = 3;
   localparam int STEP_W    = 4;

   localparam logic [MUL_BITS-1:0] K_SCALE     = 7'd100;
   localparam logic [DAC_W-1:0]    DAC_MAX     = 12'd4095;
   localparam logic [TGT_W-1:0]    TARGET_RST  = 32'd30720000;
   localparam logic [TOL_W-1:0]    TOL_RST     = 16'd15;
   localparam logic [DAC_W-1:0]    IDAC_RST    = 12'd3125;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_TARGET = 2'd0;
   localparam logic [1:0] REG_TOL    = 2'd1;
   localparam logic [1:0] REG_IDAC   = 2'd2;

   // adjust codes
   localparam logic [ADJ_W-1:0] ADJ_NONE = 2'd0;
   localparam logic [ADJ_W-1:0] ADJ_DOWN = 2'd1;
   localparam logic [ADJ_W-1:0] ADJ_UP   = 2'd2;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_READ,
      OP_SUB_OLD,
      OP_ADD_NEW,
      OP_INIT_T,
      OP_MAC_T,
      OP_MK_BAND,
      OP_MAC_FILL,
      OP_CMP,
      OP_EMIT,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_INPUT,
      C_SETTLING,
      C_LOOP_MORE,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic no_input;
      logic settling;
      logic loop_more;
      logic out_busy;
   } stat_type;

   // program addresses
   localparam step_type S_WAIT   = 4'd0;
   localparam step_type S_READ   = 4'd1;
   localparam step_type S_SUB    = 4'd2;
   localparam step_type S_ADD    = 4'd3;
   localparam step_type S_INIT_T = 4'd4;
   localparam step_type S_MAC_T  = 4'd5;
   localparam step_type S_BAND   = 4'd6;
   localparam step_type S_MAC_F  = 4'd7;
   localparam step_type S_CMP    = 4'd8;
   localparam step_type S_EMIT   = 4'd9;
   localparam step_type S_RET    = 4'd10;
   localparam step_type S_CLEAR  = 4'd11;

   // Control store: jump to target when the condition holds, else fall through.
   function automatic ucode_type ucode_fetch(input step_type s);
      ucode_type w;
      unique case (s)
         S_WAIT:   w = '{OP_LATCH,    C_NO_INPUT,  S_WAIT};
         S_READ:   w = '{OP_READ,     C_SETTLING,  S_CLEAR};
         S_SUB:    w = '{OP_SUB_OLD,  C_NEVER,     S_WAIT};
         S_ADD:    w = '{OP_ADD_NEW,  C_NEVER,     S_WAIT};
         S_INIT_T: w = '{OP_INIT_T,   C_NEVER,     S_WAIT};
         S_MAC_T:  w = '{OP_MAC_T,    C_LOOP_MORE, S_MAC_T};
         S_BAND:   w = '{OP_MK_BAND,  C_NEVER,     S_WAIT};
         S_MAC_F:  w = '{OP_MAC_FILL, C_LOOP_MORE, S_MAC_F};
         S_CMP:    w = '{OP_CMP,      C_NEVER,     S_WAIT};
         S_EMIT:   w = '{OP_EMIT,     C_OUT_BUSY,  S_EMIT};
         S_RET:    w = '{OP_NOP,      C_ALWAYS,    S_WAIT};
         S_CLEAR:  w = '{OP_CLEAR,    C_ALWAYS,    S_EMIT};
         default:  w = '{OP_NOP,      C_ALWAYS,    S_WAIT};
      endcase
      return w;
   endfunction

endpackage

// File: hdl/odl_seq.sv
// Microcode sequencer: step counter, control store fetch and jump logic.
// Depends on odl_pkg.
module odl_seq (
   input  logic                clock,
   input  logic                reset,
   input  odl_pkg::stat_type   stat,
   output odl_pkg::ucode_type  ctrl
);
   import odl_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     jump;

   assign ctrl = ucode_fetch(step_ff);

   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:    jump = 1'b1;
         C_NO_INPUT:  jump = stat.no_input;
         C_SETTLING:  jump = stat.settling;
         C_LOOP_MORE: jump = stat.loop_more;
         C_OUT_BUSY:  jump = stat.out_busy;
         default:     jump = 1'b0;
      endcase
      step_in = jump ? ctrl.target : step_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: hdl/odl_dp.sv
// Datapath: count ring memory, running sum, shift-add scaling, DAC and result register.
// Depends on odl_pkg and oscillator_discipline_loop_macros.svh; driven by odl_seq.
`include "oscillator_discipline_loop_macros.svh"
module odl_dp #(
   parameter int WINDOW      = 25,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  odl_pkg::ucode_type          ctrl,
   output odl_pkg::stat_type           stat,
   input  logic                        req_valid,
   input  logic [COUNT_WIDTH-1:0]      req_measured_count,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [odl_pkg::DAC_W-1:0]   rsp_dac_code,
   output logic [odl_pkg::ADJ_W-1:0]   rsp_adjust,
   output logic                        rsp_discarded,
   input  logic [odl_pkg::TGT_W-1:0]   cfg_target,
   input  logic [odl_pkg::TOL_W-1:0]   cfg_tolerance,
   input  logic                        cfg_dac_load,
   input  logic [odl_pkg::DAC_W-1:0]   cfg_dac_code
);
   import odl_pkg::*;

   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = COUNT_WIDTH + FILL_W;
   localparam int LHS_W  = SUM_W + MUL_BITS + 1;
   localparam int BAND_W = TGT_W + MUL_BITS + 2;
   localparam int RHS_W  = BAND_W + FILL_W;
   localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   logic [COUNT_WIDTH-1:0] ring_mem [WINDOW];
   logic [COUNT_WIDTH-1:0] rd_ff;
   logic [COUNT_WIDTH-1:0] m_ff;

   logic [SUM_W-1:0]       sum_ff;
   logic [POS_W-1:0]       pos_ff;
   logic                   full_ff;
   logic                   settling_ff;
   logic [FILL_W-1:0]      fill_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [DAC_W-1:0]       dac_ff;

   logic signed [CMP_W-1:0] acc_t_ff;
   logic signed [CMP_W-1:0] lhs_ff;
   logic signed [CMP_W-1:0] band_dn_ff;
   logic signed [CMP_W-1:0] band_up_ff;
   logic signed [CMP_W-1:0] rdn_ff;
   logic signed [CMP_W-1:0] rup_ff;
   logic                    gt_ff;
   logic                    lt_ff;
   logic                    disc_ff;

   logic                    rsp_valid_ff;
   logic [DAC_W-1:0]        rsp_dac_ff;
   logic [ADJ_W-1:0]        rsp_adjust_ff;
   logic                    rsp_disc_ff;

   logic signed [CMP_W-1:0] t_ext;
   logic signed [CMP_W-1:0] tol_ext;
   logic signed [CMP_W-1:0] sum_ext;
   logic [MUL_BITS-1:0]     fill_ext;
   logic [CNT_W-1:0]        bit_idx;
   logic                    k_bit;
   logic                    f_bit;
   logic                    out_busy;
   logic                    emit_go;
   logic [DAC_W-1:0]        dac_in;
   logic [ADJ_W-1:0]        adjust_in;
   logic                    settle_in;

   assign t_ext    = signed'({{(CMP_W-TGT_W){1'b0}}, cfg_target});
   assign tol_ext  = signed'({{(CMP_W-TOL_W){1'b0}}, cfg_tolerance});
   assign sum_ext  = signed'({{(CMP_W-SUM_W){1'b0}}, sum_ff});
   assign fill_ext = MUL_BITS'(fill_ff);
   // MSB first through the multiplier bits
   assign bit_idx  = CNT_W'(MUL_BITS - 1) - cnt_ff;
   assign k_bit    = K_SCALE[bit_idx];
   assign f_bit    = fill_ext[bit_idx];

   assign out_busy = rsp_valid_ff && rsp_stall;
   assign emit_go  = (ctrl.op == OP_EMIT) && !out_busy;

   assign stat.no_input  = !req_valid;
   assign stat.settling  = settling_ff;
   assign stat.loop_more = (cnt_ff != CNT_W'(MUL_BITS - 1));
   assign stat.out_busy  = out_busy;

   // Step decision: above the band steps down, below it steps up; limits and discards hold.
   always_comb begin
      dac_in    = dac_ff;
      adjust_in = ADJ_NONE;
      settle_in = 1'b0;
      if (!disc_ff) begin
         if (gt_ff) begin
            if (dac_ff != '0) begin
               dac_in    = dac_ff - DAC_W'(1);
               adjust_in = ADJ_DOWN;
               settle_in = 1'b1;
            end
         end else if (lt_ff) begin
            if (dac_ff != DAC_MAX) begin
               dac_in    = dac_ff + DAC_W'(1);
               adjust_in = ADJ_UP;
               settle_in = 1'b1;
            end
         end
      end
   end

   // Ring memory: one read or one write per step.
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_READ) begin
         rd_ff <= ring_mem[pos_ff];
      end
      if (ctrl.op == OP_ADD_NEW) begin
         ring_mem[pos_ff] <= m_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         settling_ff  <= 1'b0;
         cnt_ff       <= '0;
         dac_ff       <= IDAC_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (ctrl.op)
            OP_SUB_OLD: begin
               if (full_ff) begin
                  sum_ff <= sum_ff - {{(SUM_W-COUNT_WIDTH){1'b0}}, rd_ff};
               end
            end
            OP_ADD_NEW: begin
               sum_ff <= sum_ff + {{(SUM_W-COUNT_WIDTH){1'b0}}, m_ff};
               if (pos_ff == POS_W'(WINDOW - 1)) begin
                  pos_ff  <= '0;
                  full_ff <= 1'b1;
               end else begin
                  pos_ff <= pos_ff + POS_W'(1);
               end
            end
            OP_INIT_T, OP_MK_BAND: begin
               cnt_ff <= '0;
            end
            OP_MAC_T, OP_MAC_FILL: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            OP_EMIT: begin
               if (emit_go) begin
                  dac_ff      <= dac_in;
                  settling_ff <= settle_in;
               end
            end
            OP_CLEAR: begin
               sum_ff      <= '0;
               pos_ff      <= '0;
               full_ff     <= 1'b0;
               settling_ff <= 1'b0;
            end
            default: begin
            end
         endcase

         if (cfg_dac_load) begin
            dac_ff <= cfg_dac_code;
         end

         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and arithmetic registers
   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         OP_LATCH: begin
            if (req_valid) begin
               m_ff <= req_measured_count;
            end
         end
         OP_ADD_NEW: begin
            fill_ff <= full_ff ? FILL_W'(WINDOW) : FILL_W'(pos_ff) + FILL_W'(1);
         end
         OP_INIT_T: begin
            acc_t_ff <= '0;
            lhs_ff   <= '0;
         end
         OP_MAC_T: begin
            acc_t_ff <= (acc_t_ff <<< 1) + (k_bit ? t_ext : '0);
            lhs_ff   <= (lhs_ff <<< 1) + (k_bit ? sum_ext : '0);
         end
         OP_MK_BAND: begin
            band_dn_ff <= acc_t_ff + tol_ext;
            band_up_ff <= acc_t_ff - tol_ext;
            rdn_ff     <= '0;
            rup_ff     <= '0;
         end
         OP_MAC_FILL: begin
            rdn_ff <= (rdn_ff <<< 1) + (f_bit ? band_dn_ff : '0);
            rup_ff <= (rup_ff <<< 1) + (f_bit ? band_up_ff : '0);
         end
         OP_CMP: begin
            gt_ff   <= lhs_ff > rdn_ff;
            lt_ff   <= lhs_ff < rup_ff;
            disc_ff <= 1'b0;
         end
         OP_CLEAR: begin
            gt_ff   <= 1'b0;
            lt_ff   <= 1'b0;
            disc_ff <= 1'b1;
         end
         OP_EMIT: begin
            if (emit_go) begin
               rsp_dac_ff    <= dac_in;
               rsp_adjust_ff <= adjust_in;
               rsp_disc_ff   <= disc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dac_code  = rsp_dac_ff;
   assign rsp_adjust    = rsp_adjust_ff;
   assign rsp_discarded = rsp_disc_ff;

   `ODL_ASSERT_NOW(a_pos_in_window, 1'b1, pos_ff <= POS_W'(WINDOW - 1), "write position left window")
   `ODL_ASSERT_NEXT(a_full_fill, ctrl.op == OP_ADD_NEW && full_ff, fill_ff == FILL_W'(WINDOW), "full ring not averaged over window")
   `ODL_ASSERT_NEXT(a_step_settles, emit_go && adjust_in != ADJ_NONE, settling_ff, "DAC step without settling")
   `ODL_ASSERT_NOW(a_discard_no_step, rsp_valid_ff && rsp_disc_ff, rsp_adjust_ff == ADJ_NONE, "discarded transaction reports a step")

endmodule

// File: hdl/oscillator_discipline_loop.sv
// An accepted measurement runs read, subtract, add, the two 7-step shift-add loops, band,
// compare and emit; a discarded one runs read, clear and emit, before the next is taken;
// a result still stalled downstream holds the emit step and the intake.
// Reset: synchronous, active high; ring empty, sum zero, DAC at 3125, registers at defaults.
// Ring entries have no reset value; a read before the write goes unused; no clearing pass.
// Depends on odl_pkg, odl_seq and odl_dp.
module oscillator_discipline_loop #(
   parameter int WINDOW      = 25,   // averaging window, 1..64 entries
   parameter int COUNT_WIDTH = 32    // bits of the measured count used, 26..40
) (
   input  logic                         clock,
   input  logic                         reset,
   // measurement channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [COUNT_WIDTH-1:0]       req_measured_count,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [odl_pkg::DAC_W-1:0]    rsp_dac_code,
   output logic [odl_pkg::ADJ_W-1:0]    rsp_adjust,
   output logic                         rsp_discarded,
   // register port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [odl_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [odl_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [odl_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import odl_pkg::*;

   ucode_type           ctrl;
   stat_type            stat;

   logic [TGT_W-1:0]    target_ff;
   logic [TOL_W-1:0]    tol_ff;
   logic [DAC_W-1:0]    idac_ff;
   logic [1:0]          reg_idx;
   logic                csr_wr;
   logic                dac_load;

   // Register port: zero wait states, index from the word address.
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   // Writing initial_dac also reloads the live DAC value.
   assign dac_load   = csr_wr && (reg_idx == REG_IDAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RST;
         tol_ff    <= TOL_RST;
         idac_ff   <= IDAC_RST;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_TARGET: target_ff <= csr_pwdata;
            REG_TOL:    tol_ff    <= csr_pwdata[TOL_W-1:0];
            REG_IDAC:   idac_ff   <= csr_pwdata[DAC_W-1:0];
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TARGET: csr_prdata = target_ff;
         REG_TOL:    csr_prdata = {{(CSR_DW-TOL_W){1'b0}}, tol_ff};
         REG_IDAC:   csr_prdata = {{(CSR_DW-DAC_W){1'b0}}, idac_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // Take a measurement only at the wait step of the program. The result register
   // holds the previous result; while it is still stalled the program waits at the
   // emit step, so intake then waits on the consumer.
   assign req_stall = (ctrl.op != OP_LATCH);

   odl_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   odl_dp #(
      .WINDOW      (WINDOW),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .stat               (stat),
      .req_valid          (req_valid),
      .req_measured_count (req_measured_count),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_dac_code       (rsp_dac_code),
      .rsp_adjust         (rsp_adjust),
      .rsp_discarded      (rsp_discarded),
      .cfg_target         (target_ff),
      .cfg_tolerance      (tol_ff),
      .cfg_dac_load       (dac_load),
      .cfg_dac_code       (csr_pwdata[DAC_W-1:0])
   );

endmodule
